// ----- sv/quaternion_to_euler_angles_macros.svh -----
// Assertion macros shared by the quaternion to Euler angle RTL
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define QTE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("qte check failed");

// next-cycle implication, clocked on aclk, off during reset
`define QTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("qte check failed");

`endif

// ----- sv/qte_pkg.sv -----
// Types, constants and helper functions for the quaternion to Euler angle block
`default_nettype none
package qte_pkg;

    localparam int QW          = 16;   // quaternion component width
    localparam int AW          = 16;   // output angle width
    localparam int SW          = 34;   // sine/cosine term width (Q30, range +-2^32)
    localparam int CW          = 37;   // CORDIC x/y width, room for gain and pre-rotation
    localparam int ZW          = 34;   // angle accumulator, 2^32 per turn
    localparam int RW          = 61;   // radicand width, up to 2^60
    localparam int SQW         = 62;   // square root running result width
    localparam int SQRT_STEPS  = 31;   // one result bit per cell
    localparam int TABLE_LEN   = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [SW-1:0] ONE_Q30      = SW'(64'sd1073741824);
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);
    localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'sd2147483648);
    localparam logic signed [AW-1:0] PITCH_UP     = 16'sd16384;
    localparam logic signed [AW-1:0] PITCH_DOWN   = -16'sd16384;

    typedef struct packed {
        logic                   hold;   // angle settled before rotations (zero sine part)
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
        logic signed [ZW-1:0]   z;
    } cordic_t;

    typedef struct packed {
        logic [RW-1:0]          v;
        logic [SQW-1:0]         res;
        logic signed [SW-1:0]   sp;     // pitch sine rides along
    } sqrt_t;

    // round(atan(2^-i) * 2^32 / (2 pi))
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10679838;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // zero-sine shortcut and quarter-turn move into the right half plane
    function automatic cordic_t cordic_pre(input logic signed [SW-1:0] s,
                                           input logic signed [SW-1:0] c);
        cordic_t r;
        logic signed [CW-1:0] sx, cx;
        sx = CW'(s);
        cx = CW'(c);
        r.hold = 1'b0;
        r.x    = cx;
        r.y    = sx;
        r.z    = '0;
        if (s == '0) begin
            r.hold = 1'b1;
            r.z    = (c < 0) ? HALF_TURN : '0;
        end else if (c < 0) begin
            if (s > 0) begin
                r.x = sx;
                r.y = -cx;
                r.z = QUARTER_TURN;
            end else begin
                r.x = -sx;
                r.y = cx;
                r.z = -QUARTER_TURN;
            end
        end
        return r;
    endfunction

    // floor((a + 32768) / 65536) modulo 2^16
    function automatic logic [AW-1:0] to_angle16(input logic signed [ZW-1:0] a);
        logic signed [ZW-1:0] t;
        t = a + ZW'(32768);
        return t[31:16];
    endfunction

endpackage
`default_nettype wire

// ----- sv/qte_cordic_cell.sv -----
// One vectoring CORDIC micro-rotation, registered
`default_nettype none
module qte_cordic_cell
    import qte_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic    aclk,
    input  wire logic    en,
    input  wire cordic_t cell_in,
    output cordic_t      cell_out_reg
);

    cordic_t cell_next;
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] da;

    assign xs = cell_in.x >>> STEP;
    assign ys = cell_in.y >>> STEP;
    assign da = ZW'(atan_entry(5'(STEP)));

    always_comb begin
        cell_next = cell_in;
        if (!cell_in.hold) begin
            if (cell_in.y >= 0) begin
                cell_next.x = cell_in.x + ys;
                cell_next.y = cell_in.y - xs;
                cell_next.z = cell_in.z + da;
            end else begin
                cell_next.x = cell_in.x - ys;
                cell_next.y = cell_in.y + xs;
                cell_next.z = cell_in.z - da;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_out_reg <= cell_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/qte_sqrt_cell.sv -----
// One bit of the digit-by-digit integer square root, registered
`default_nettype none
module qte_sqrt_cell
    import qte_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic  aclk,
    input  wire logic  en,
    input  wire sqrt_t cell_in,
    output sqrt_t      cell_out_reg
);

    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQRT_STEPS - 1 - STEP));

    sqrt_t cell_next;
    logic [SQW-1:0] trial;

    assign trial = cell_in.res + BIT;

    always_comb begin
        cell_next = cell_in;
        if (SQW'(cell_in.v) >= trial) begin
            cell_next.v   = cell_in.v - RW'(trial);
            cell_next.res = (cell_in.res >> 1) + BIT;
        end else begin
            cell_next.res = cell_in.res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_out_reg <= cell_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/quaternion_to_euler_angles.sv -----
// Top level: quaternion to roll, pitch and yaw binary angles
`default_nettype none
// Fully pipelined: one quaternion accepted per cycle while the output buffer is not
// full (two products/sums stages, a squaring stage, 31 square-root cells for the
// pitch cosine and a CORDIC cell row per angle, then one output register; the pitch
// path is the longest). Angles are 65536 per turn.
// A two-entry output buffer lets input continue while one result waits.
`include "quaternion_to_euler_angles_macros.svh"
module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // roll_angle, pitch_angle, yaw_angle, pitch_clamped
);

    localparam int PIPE = CORDIC_STEPS + 36;   // stages up to the last cell
    localparam int RYD  = 33;                  // roll/yaw wait for the sqrt path
    localparam int CLD  = PIPE - 2;            // clamp info from stage 3 to the end

    logic en;
    logic [PIPE-1:0] vld_reg;

    logic signed [QW-1:0] qx, qy, qz, qw;
    assign qx = s_tdata[15:0];
    assign qy = s_tdata[31:16];
    assign qz = s_tdata[47:32];
    assign qw = s_tdata[63:48];

    // stage 1: products
    logic signed [2*QW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg;
    logic signed [2*QW-1:0] wz_reg, xy_reg, zz_reg;
    // stage 2: sine and cosine terms
    logic signed [SW-1:0] sr_reg, cr_reg, sp_reg, sy_reg, cy_reg;
    // stage 3
    logic signed [2*31-1:0] sq_reg;
    logic signed [SW-1:0]   sp3_reg;
    logic [1:0]             cl_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            wy_reg <= qw * qy;
            zx_reg <= qz * qx;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            zz_reg <= qz * qz;
            sr_reg <= (SW'(wx_reg) + SW'(yz_reg)) <<< 1;
            cr_reg <= ONE_Q30 - ((SW'(xx_reg) + SW'(yy_reg)) <<< 1);
            sp_reg <= (SW'(wy_reg) - SW'(zx_reg)) <<< 1;
            sy_reg <= (SW'(wz_reg) + SW'(xy_reg)) <<< 1;
            cy_reg <= ONE_Q30 - ((SW'(yy_reg) + SW'(zz_reg)) <<< 1);
            sq_reg <= $signed(sp_reg[30:0]) * $signed(sp_reg[30:0]);
            sp3_reg <= sp_reg;
        end
    end

    // clamp flag in bit 1, direction (1 = down) in bit 0
    assign cl_next = (sp_reg >= ONE_Q30)  ? 2'b10 :
                     (sp_reg <= -ONE_Q30) ? 2'b11 : 2'b00;

    // roll, yaw and pitch CORDIC rows and the square-root cells
    cordic_t rc [0:CORDIC_STEPS];
    cordic_t yc [0:CORDIC_STEPS];
    cordic_t pc [0:CORDIC_STEPS];
    sqrt_t   sc [0:SQRT_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            rc[0] <= cordic_pre(sr_reg, cr_reg);
            yc[0] <= cordic_pre(sy_reg, cy_reg);
            sc[0].v   <= (RW'(1) << (RW - 1)) - RW'(sq_reg);
            sc[0].res <= '0;
            sc[0].sp  <= sp3_reg;
            pc[0] <= cordic_pre(sc[SQRT_STEPS].sp,
                                SW'(sc[SQRT_STEPS].res[30:0]));
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
            qte_cordic_cell #(.STEP(gi)) u_roll (
                .aclk(aclk), .en(en), .cell_in(rc[gi]), .cell_out_reg(rc[gi+1]));
            qte_cordic_cell #(.STEP(gi)) u_yaw (
                .aclk(aclk), .en(en), .cell_in(yc[gi]), .cell_out_reg(yc[gi+1]));
            qte_cordic_cell #(.STEP(gi)) u_pitch (
                .aclk(aclk), .en(en), .cell_in(pc[gi]), .cell_out_reg(pc[gi+1]));
        end
        for (gi = 0; gi < SQRT_STEPS; gi++) begin : g_sqrt
            qte_sqrt_cell #(.STEP(gi)) u_sqrt (
                .aclk(aclk), .en(en), .cell_in(sc[gi]), .cell_out_reg(sc[gi+1]));
        end
    endgenerate

    // delay lines to line up with the pitch path
    logic [2*AW-1:0] ry_dly_reg [0:RYD-1];
    logic [1:0]      cl_dly_reg [0:CLD-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            ry_dly_reg[0] <= {to_angle16(yc[CORDIC_STEPS].z), to_angle16(rc[CORDIC_STEPS].z)};
            for (int i = 1; i < RYD; i++) begin
                ry_dly_reg[i] <= ry_dly_reg[i-1];
            end
            cl_dly_reg[0] <= cl_next;
            for (int i = 1; i < CLD; i++) begin
                cl_dly_reg[i] <= cl_dly_reg[i-1];
            end
        end
    end

    // final result
    logic [55:0] res_next;
    logic [1:0]  cl_end;
    logic [AW-1:0] pitch_end;
    assign cl_end    = cl_dly_reg[CLD-1];
    assign pitch_end = !cl_end[1] ? to_angle16(pc[CORDIC_STEPS].z) :
                       (cl_end[0] ? PITCH_DOWN : PITCH_UP);
    assign res_next  = {7'd0, cl_end[1], ry_dly_reg[RYD-1][2*AW-1:AW], pitch_end,
                        ry_dly_reg[RYD-1][AW-1:0]};

    // valid tracking and output buffer
    logic        out_valid_reg, skid_valid_reg;
    logic [55:0] out_data_reg, skid_data_reg;
    logic        take, pop;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign take     = en && vld_reg[PIPE-1];
    assign pop      = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[PIPE-2:0], s_tvalid};
            end
            if (!out_valid_reg || pop) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= take;
                end
            end else if (take) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_next;
        end else if (take) begin
            skid_data_reg <= res_next;
        end
    end

    `QTE_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `QTE_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !m_tready, skid_valid_reg)
    `QTE_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[0])
    `QTE_ASSERT_SAME(a_clamp_value, m_tvalid && m_tdata[48],
                     m_tdata[31:16] == PITCH_UP || m_tdata[31:16] == PITCH_DOWN)

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Testbench for quaternion_to_euler_angles: directed and random items checked by a predictor or given angles
module testbench
    import qte_pkg::*;
();

    localparam int STEPS    = CORDIC_STEPS_DEF;
    localparam int LATENCY  = STEPS + 40;
    localparam int N_RANDOM = 1000;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } euler_t;

    typedef struct {
        logic signed [15:0] x, y, z, w;
        logic               known;
        euler_t             res;
    } quat_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    euler_t angles_due[$];
    int     n_errors = 0;
    bit     long_hold = 1'b0;

    quaternion_to_euler_angles DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #50000000;
        $display("testbench: FAIL");
        $finish;
    end

    // arithmetic shift rounding toward minus infinity
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint atan_turns(longint s, longint c);
        longint x = c, y = s, a = 0, t, xs, ys;
        longint tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        if (y == 0) return (x < 0) ? 64'sd2147483648 : 0;
        if (x < 0) begin
            t = x;
            if (y > 0) begin
                x = y; y = -t; a = 64'sd1073741824;
            end else begin
                x = -y; y = t; a = -64'sd1073741824;
            end
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; a += tab[i];
            end else begin
                x = x - ys; y = y + xs; a -= tab[i];
            end
        end
        return a;
    endfunction

    function automatic logic [15:0] angle16(longint a);
        longint t = floor_shift(a + 32768, 16);
        return t[15:0];
    endfunction

    function automatic euler_t euler_of(logic signed [15:0] qx, logic signed [15:0] qy,
                                        logic signed [15:0] qz, logic signed [15:0] qw);
        euler_t e;
        longint x = qx, y = qy, z = qz, w = qw;
        longint one = 64'sd1073741824;
        longint sr = 2 * (w * x + y * z);
        longint cr = one - 2 * (x * x + y * y);
        longint sp = 2 * (w * y - z * x);
        longint sy = 2 * (w * z + x * y);
        longint cy = one - 2 * (y * y + z * z);
        e.clamped = 1'b0;
        if (sp >= one) begin
            e.pitch = 16'sd16384; e.clamped = 1'b1;
        end else if (sp <= -one) begin
            e.pitch = -16'sd16384; e.clamped = 1'b1;
        end else begin
            e.pitch = angle16(atan_turns(sp, int_sqrt((64'd1 << 60) - sp * sp)));
        end
        e.roll = angle16(atan_turns(sr, cr));
        e.yaw  = angle16(atan_turns(sy, cy));
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what,
                 $signed(got), $signed(want), $time);
        n_errors++;
    endtask

    task automatic wait_gap(int max_short);
        int n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                             : $urandom_range(0, max_short);
        if (n != 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    // offers one item and holds it until accepted
    task automatic send_quat(logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                             logic [15:0] qw, bit known, euler_t want);
        euler_t e;
        if (known) e = want;
        else e = euler_of(qx, qy, qz, qw);
        s_tvalid <= 1'b1;
        s_tdata  <= {qw, qz, qy, qx};
        do @(posedge aclk); while (!s_tready);
        angles_due.push_back(e);
        @(negedge aclk);
    endtask

    // receiver: random stalls plus one long hold
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) m_tready <= 1'b0;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (angles_due.size() == 0) begin
                $display("unexpected result %h at %0t", m_tdata, $time);
                n_errors++;
            end else begin
                euler_t e;
                e = angles_due.pop_front();
                if (m_tdata[15:0] !== e.roll) report_mismatch("roll", m_tdata[15:0], e.roll);
                if (m_tdata[31:16] !== e.pitch)
                    report_mismatch("pitch", m_tdata[31:16], e.pitch);
                if (m_tdata[47:32] !== e.yaw) report_mismatch("yaw", m_tdata[47:32], e.yaw);
                if (m_tdata[48] !== e.clamped)
                    report_mismatch("clamp", {15'd0, m_tdata[48]}, {15'd0, e.clamped});
                if (m_tdata[55:49] !== '0)
                    report_mismatch("pad", {9'd0, m_tdata[55:49]}, 16'd0);
            end
        end
    end

    initial begin
        quat_row_t rows[$];
        euler_t    z;
        int        n;
        logic [15:0] a, b, c, d;
        z = '{default: '0};
        // identity, zero quaternion, clamps, half-turn sign, extremes
        rows.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b1, z});
        rows.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, z});
        rows.push_back('{16'sd0, 16'sd16385, 16'sd0, 16'sd32767, 1'b1,
                         '{16'sd0, 16'sd16384, 16'sd0, 1'b1}});
        rows.push_back('{16'sd0, -16'sd16385, 16'sd0, 16'sd32767, 1'b1,
                         '{16'sd0, -16'sd16384, 16'sd0, 1'b1}});
        rows.push_back('{16'sd0, 16'sd23170, 16'sd0, 16'sd23170, 1'b0, z});
        rows.push_back('{16'sd0, -16'sd23170, 16'sd0, 16'sd23170, 1'b0, z});
        rows.push_back('{16'sd0, -16'sd32768, 16'sd0, -16'sd32768, 1'b0, z});
        rows.push_back('{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0, z});
        rows.push_back('{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 1'b0, z});
        rows.push_back('{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 1'b0, z});
        rows.push_back('{16'sd0, 16'sd32767, 16'sd0, 16'sd0, 1'b0, z});
        rows.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, z});
        rows.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, z});
        rows.push_back('{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b0, z});
        rows.push_back('{16'sd23170, 16'sd0, 16'sd0, 16'sd23170, 1'b0, z});
        rows.push_back('{16'sd0, 16'sd0, 16'sd23170, -16'sd23170, 1'b0, z});
        rows.push_back('{16'sd100, -16'sd200, 16'sd300, 16'sd1, 1'b0, z});
        rows.push_back('{16'sd1, 16'sd1, 16'sd1, 16'sd1, 1'b0, z});

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (rows[i])
            send_quat(rows[i].x, rows[i].y, rows[i].z, rows[i].w, rows[i].known, rows[i].res);

        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                a = 16'($urandom); b = 16'($urandom);
                c = 16'($urandom); d = 16'($urandom);
            end else begin
                // near-unit quaternions, some near gimbal lock
                real ax, ay, az, aw, m;
                ax = $urandom_range(0, 20000) - 10000.0;
                ay = (i % 7 == 0) ? 10000.0 : $urandom_range(0, 20000) - 10000.0;
                az = $urandom_range(0, 20000) - 10000.0;
                aw = (i % 7 == 0) ? 10000.0 + $urandom_range(0, 40) - 20.0
                                  : $urandom_range(0, 20000) - 10000.0;
                m = $sqrt(ax * ax + ay * ay + az * az + aw * aw) + 1.0;
                a = 16'(int'(ax / m * 32767.0)); b = 16'(int'(ay / m * 32767.0));
                c = 16'(int'(az / m * 32767.0)); d = 16'(int'(aw / m * 32767.0));
            end
            send_quat(a, b, c, d, 1'b0, z);
            if (i == 300) begin
                // let the block back up while input keeps coming
                long_hold = 1'b1;
                fork
                    begin
                        repeat (LATENCY * 3) @(negedge aclk);
                        long_hold = 1'b0;
                    end
                join_none
            end else if (i == 600) begin
                s_tvalid <= 1'b0;
                while (angles_due.size() != 0) @(negedge aclk);
            end else if (!long_hold && $urandom_range(0, 2) == 0) begin
                wait_gap(3);
            end
        end
        s_tvalid <= 1'b0;

        n = 0;
        while (angles_due.size() != 0 && n < 200000) begin
            @(negedge aclk);
            n++;
        end
        repeat (LATENCY) @(negedge aclk);
        if (n_errors == 0 && angles_due.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
